// ===== sv/kms_pkg.sv =====
package kms_pkg;

   typedef struct packed {
      logic [47:0] saved_weight;
      logic [47:0] tree_weight;
      logic [9:0]  tree_edges;
      logic        spanning;
      logic        input_dropped;
   } result_type;

   localparam int unsigned VID_BITS = 10;
   localparam int unsigned SUM_BITS = 48;
   localparam int unsigned MAX_VERTICES = 1024;

endpackage

// ===== sv/kms_sorter.sv =====
// Stable insertion sort of the edge store over one read and one write port.
// Edges are packed as {weight, dst, src}.
module kms_sorter #(
   parameter int unsigned AW = 12,
   parameter int unsigned EW = 52,
   parameter int unsigned WB = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [AW:0]   count,
   output logic          done,
   output logic          mem_we,
   output logic [AW-1:0] mem_waddr,
   output logic [EW-1:0] mem_wdata,
   output logic [AW-1:0] mem_raddr,
   input  logic [EW-1:0] mem_rdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RKEY = 3'd1;
   localparam logic [2:0] S_WKEY = 3'd2;
   localparam logic [2:0] S_RPRV = 3'd3;
   localparam logic [2:0] S_CMP  = 3'd4;
   localparam logic [2:0] S_PUT  = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [AW:0]   i_ff, i_in;
   logic [AW:0]   j_ff, j_in;
   logic [EW-1:0] key_ff, key_in;

   logic [WB-1:0] key_w, prv_w;
   assign key_w = key_ff[EW-1 -: WB];
   assign prv_w = mem_rdata[EW-1 -: WB];

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      key_in    = key_ff;
      done      = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = j_ff[AW-1:0];
      mem_wdata = key_ff;
      mem_raddr = i_ff[AW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               i_in     = (AW+1)'(1);
               state_in = S_RKEY;
            end
         end
         S_RKEY: begin
            if (i_ff >= count) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end else begin
               j_in     = i_ff;
               state_in = S_WKEY;
            end
         end
         S_WKEY: begin
            key_in    = mem_rdata;
            mem_raddr = j_ff[AW-1:0] - AW'(1);
            state_in  = S_RPRV;
         end
         S_RPRV: begin
            mem_raddr = j_ff[AW-1:0] - AW'(1);
            state_in  = S_CMP;
         end
         S_CMP: begin
            if (prv_w > key_w) begin
               mem_we    = 1'b1;
               mem_wdata = mem_rdata;
               j_in      = j_ff - (AW+1)'(1);
               if (j_ff == (AW+1)'(1)) state_in = S_PUT;
               else begin
                  mem_raddr = j_ff[AW-1:0] - AW'(2);
                  state_in  = S_CMP;
               end
            end else begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            mem_we   = 1'b1;
            i_in     = i_ff + (AW+1)'(1);
            state_in = S_RKEY;
            mem_raddr = i_ff[AW-1:0] + AW'(1);
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
      key_ff <= key_in;
   end

endmodule

// ===== sv/kruskal_mst_savings_top.sv =====
// Kruskal minimum spanning forest over a batch of weighted edges.
// req_ channel: one edge per item, accepted whenever valid while the
// batch loads; tlast marks the final edge of the batch. An edge with an
// endpoint >= vertex_count, or one arriving with the store full, is dropped
// and flagged. After the last item the block drops req_tready and runs:
// a stable insertion sort of the stored edges (quadratic in the worst case,
// on the shared edge memory), an init sweep over the live entries of the
// parent/rank memory, then one union-find pass per sorted edge until the
// edges run out or the forest spans. One rsp_ item carries the result; the
// block holds it until rsp_tready and then takes new edges. A stall on rsp_
// only delays the return to loading. Reset (synchronous) empties the store,
// clears the sum and drop flag and sets vertex_count to 1024; csr_ writes
// vertex_count and is to be used only while the block is idle: the user
// must keep to this, as the block itself does not enforce it.
module kruskal_mst_savings_top #(
   parameter int unsigned MAX_EDGES    = 4096,
   parameter int unsigned WEIGHT_BITS  = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [10:0]   csr_wdata,        // vertex_count
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [55:0]   req_tdata,        // src_vertex, dst_vertex, edge_weight, pad
   input  logic          req_tlast,        // last_edge
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [111:0]  rsp_tdata         // saved_weight, tree_weight, tree_edges,
                                           // spanning, input_dropped, pad
);

   localparam int unsigned MAX_VERTICES = kms_pkg::MAX_VERTICES;
   localparam int unsigned AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int unsigned VW = $clog2(MAX_VERTICES);
   localparam int unsigned EW = WEIGHT_BITS + 20;
   localparam int unsigned SB = kms_pkg::SUM_BITS;

   localparam logic [3:0] S_LOAD = 4'd0;
   localparam logic [3:0] S_SORT = 4'd1;
   localparam logic [3:0] S_INIT = 4'd2;
   localparam logic [3:0] S_EDGE = 4'd3;
   localparam logic [3:0] S_ELAT = 4'd4;
   localparam logic [3:0] S_FIND = 4'd5;
   localparam logic [3:0] S_FLAT = 4'd6;
   localparam logic [3:0] S_COMP = 4'd7;
   localparam logic [3:0] S_CLAT = 4'd8;
   localparam logic [3:0] S_JOIN = 4'd9;
   localparam logic [3:0] S_OUT  = 4'd10;
   localparam logic [3:0] S_SGO  = 4'd11;
   localparam logic [3:0] S_RNK  = 4'd12;

   logic [9:0]  req_src, req_dst;
   logic [31:0] req_w;
   assign req_src = req_tdata[9:0];
   assign req_dst = req_tdata[19:10];
   assign req_w   = req_tdata[51:20];

   logic [10:0] vcnt_ff;
   logic [10:0] nv;
   always_comb begin
      if (vcnt_ff == 11'd0) nv = 11'd1;
      else if (32'(vcnt_ff) > MAX_VERTICES) nv = 11'(MAX_VERTICES);
      else nv = vcnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) vcnt_ff <= 11'd1024;
      else if (csr_we) vcnt_ff <= csr_wdata;
   end

   // edge memory
   logic [EW-1:0] emem [MAX_EDGES];
   logic [EW-1:0] erd_ff;
   logic          ewe;
   logic [AW-1:0] ewa, era;
   logic [EW-1:0] ewd;
   always_ff @(posedge clock) begin
      if (ewe) emem[ewa] <= ewd;
      erd_ff <= emem[era];
   end

   // parent/rank memory
   logic [VW+3:0] pmem [MAX_VERTICES];
   logic [VW+3:0] prd_ff;
   logic          pwe;
   logic [VW-1:0] pwa, pra;
   logic [VW+3:0] pwd;
   always_ff @(posedge clock) begin
      if (pwe) pmem[pwa] <= pwd;
      prd_ff <= pmem[pra];
   end

   logic [3:0]    state_ff, state_in;
   logic [AW:0]   fill_ff, fill_in;
   logic [SB-1:0] total_ff, total_in;
   logic          drop_ff, drop_in;
   logic [AW:0]   idx_ff, idx_in;
   logic [10:0]   vi_ff, vi_in;
   logic [10:0]   chosen_ff, chosen_in;
   logic [SB-1:0] tree_ff, tree_in;
   logic [EW-1:0] cur_ff, cur_in;
   logic          side_ff, side_in;      // 0: finding src root, 1: dst
   logic [VW-1:0] walk_ff, walk_in;
   logic [VW-1:0] rootA_ff, rootA_in;
   logic [3:0]    rankA_ff, rankA_in;
   logic [VW-1:0] root_ff, root_in;
   logic [3:0]    rank_ff, rank_in;
   kms_pkg::result_type res_ff, res_in;

   logic          srt_start, srt_done, s_we;
   logic [AW-1:0] s_wa, s_ra;
   logic [EW-1:0] s_wd;

   kms_sorter #(.AW(AW), .EW(EW), .WB(WEIGHT_BITS)) u_sort (
      .clock(clock), .reset(reset), .start(srt_start), .count(fill_ff),
      .done(srt_done), .mem_we(s_we), .mem_waddr(s_wa), .mem_wdata(s_wd),
      .mem_raddr(s_ra), .mem_rdata(erd_ff)
   );

   logic          acc, bad;
   logic [WEIGHT_BITS-1:0] wv;
   logic [VW-1:0] cur_src, cur_dst;
   logic [WEIGHT_BITS-1:0] cur_w;
   logic [VW-1:0] pr_par;
   logic [3:0]    pr_rank;
   assign cur_src = cur_ff[VW-1:0];
   assign cur_dst = cur_ff[10 +: VW];
   assign cur_w   = cur_ff[EW-1 -: WEIGHT_BITS];
   assign pr_par  = prd_ff[VW-1:0];
   assign pr_rank = prd_ff[VW +: 4];
   assign wv      = WEIGHT_BITS'(req_w);

   assign req_tready = (state_ff == S_LOAD);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {4'd0, res_ff.input_dropped, res_ff.spanning, res_ff.tree_edges,
                        res_ff.tree_weight, res_ff.saved_weight};
   assign acc = req_tvalid && req_tready;
   assign bad = (11'(req_src) >= nv) || (11'(req_dst) >= nv)
                || (fill_ff == (AW+1)'(MAX_EDGES));

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      total_in  = total_ff;
      drop_in   = drop_ff;
      idx_in    = idx_ff;
      vi_in     = vi_ff;
      chosen_in = chosen_ff;
      tree_in   = tree_ff;
      cur_in    = cur_ff;
      side_in   = side_ff;
      walk_in   = walk_ff;
      rootA_in  = rootA_ff;
      rankA_in  = rankA_ff;
      root_in   = root_ff;
      rank_in   = rank_ff;
      res_in    = res_ff;
      srt_start = 1'b0;
      ewe = s_we;
      ewa = s_wa;
      ewd = s_wd;
      era = s_ra;
      pwe = 1'b0;
      pwa = vi_ff[VW-1:0];
      pwd = {4'd0, vi_ff[VW-1:0]};
      pra = walk_ff;
      unique case (state_ff)
         S_LOAD: begin
            ewe = 1'b0;
            era = '0;
            if (acc) begin
               if (bad) drop_in = 1'b1;
               else begin
                  ewe      = 1'b1;
                  ewa      = fill_ff[AW-1:0];
                  ewd      = {wv, 10'(req_dst), 10'(req_src)};
                  fill_in  = fill_ff + (AW+1)'(1);
                  total_in = total_ff + SB'(wv);
               end
               if (req_tlast) state_in = S_SGO;
            end
         end
         S_SGO: begin
            srt_start = 1'b1;
            era       = '0;
            state_in  = S_SORT;
         end
         S_SORT: begin
            if (srt_done) begin
               vi_in    = '0;
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            pwe = 1'b1;
            if (vi_ff + 11'd1 >= nv) begin
               idx_in    = '0;
               chosen_in = '0;
               tree_in   = '0;
               state_in  = S_EDGE;
            end
            vi_in = vi_ff + 11'd1;
         end
         S_EDGE: begin
            era = idx_ff[AW-1:0];
            if (idx_ff >= fill_ff || chosen_ff >= nv - 11'd1) begin
               res_in.saved_weight  = total_ff - tree_ff;
               res_in.tree_weight   = tree_ff;
               res_in.tree_edges    = chosen_ff[9:0];
               res_in.spanning      = (chosen_ff == nv - 11'd1);
               res_in.input_dropped = drop_ff;
               state_in = S_OUT;
            end else state_in = S_ELAT;
         end
         S_ELAT: begin
            cur_in   = erd_ff;
            walk_in  = erd_ff[VW-1:0];
            side_in  = 1'b0;
            state_in = S_FIND;
         end
         S_FIND: begin
            state_in = S_FLAT;    // read parent of walk
         end
         S_FLAT: begin
            if (pr_par == walk_ff) begin
               root_in  = walk_ff;
               rank_in  = pr_rank;
               walk_in  = side_ff ? cur_dst : cur_src;
               state_in = S_COMP;
            end else begin
               walk_in  = pr_par;
               state_in = S_FIND;
            end
         end
         S_COMP: begin
            state_in = S_CLAT;
         end
         S_CLAT: begin
            // path compression: point every node on the path to root
            if (pr_par == root_ff || walk_ff == root_ff) begin
               if (!side_ff) begin
                  rootA_in = root_ff;
                  rankA_in = rank_ff;
                  side_in  = 1'b1;
                  walk_in  = cur_dst;
                  state_in = S_FIND;
               end else state_in = S_JOIN;
            end else begin
               pwe      = 1'b1;
               pwa      = walk_ff;
               pwd      = {prd_ff[VW +: 4], root_ff};
               walk_in  = pr_par;
               state_in = S_COMP;
            end
         end
         S_JOIN: begin
            if (rootA_ff != root_ff) begin
               chosen_in = chosen_ff + 11'd1;
               tree_in   = tree_ff + SB'(cur_w);
               pwe = 1'b1;
               if (rankA_ff < rank_ff) begin
                  pwa = rootA_ff;
                  pwd = {rankA_ff, root_ff};
               end else if (rankA_ff > rank_ff) begin
                  pwa = root_ff;
                  pwd = {rank_ff, rootA_ff};
               end else begin
                  pwa = root_ff;
                  pwd = {rank_ff, rootA_ff};
               end
            end
            idx_in   = idx_ff + (AW+1)'(1);
            state_in = S_EDGE;
            if (rootA_ff != root_ff && rankA_ff == rank_ff && rankA_ff != 4'd15) begin
               // bump rank of surviving root on a spare cycle
               rankA_in = rankA_ff + 4'd1;
               state_in = S_RNK;
            end
         end
         S_RNK: begin
            pwe      = 1'b1;
            pwa      = rootA_ff;
            pwd      = {rankA_ff, rootA_ff};
            state_in = S_EDGE;
         end
         S_OUT: begin
            if (rsp_tready) begin
               fill_in  = '0;
               total_in = '0;
               drop_in  = 1'b0;
               state_in = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         fill_ff  <= '0;
         total_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
         drop_ff  <= drop_in;
      end
      idx_ff    <= idx_in;
      vi_ff     <= vi_in;
      chosen_ff <= chosen_in;
      tree_ff   <= tree_in;
      cur_ff    <= cur_in;
      side_ff   <= side_in;
      walk_ff   <= walk_in;
      rootA_ff  <= rootA_in;
      rankA_ff  <= rankA_in;
      root_ff   <= root_in;
      rank_ff   <= rank_in;
      res_ff    <= res_in;
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   localparam int unsigned NUM_VERTICES = 1024;
   localparam int unsigned EDGE_CAP     = 4096;
   localparam int unsigned RANDOM_EDGES = 950;
   localparam int unsigned STALL_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 50;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_we = 1'b0;
   logic [10:0]   csr_wdata = '0;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [55:0]   req_tdata = '0;    // src_vertex, dst_vertex, edge_weight, pad
   logic          req_tlast = 1'b0;  // last_edge
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [111:0]  rsp_tdata;         // saved_weight, tree_weight, tree_edges,
                                     // spanning, input_dropped, pad

   kruskal_mst_savings_top dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct {
      logic [9:0]  src;
      logic [9:0]  dst;
      logic [31:0] wt;
      logic        last;
      logic        known;   // expected result typed in below
      logic [47:0] saved;
      logic [47:0] tree;
      logic [9:0]  nedges;
      logic        span;
      logic        dropped;
   } edge_row_type;

   // batch state of the predictor
   logic [9:0]  batch_src[$];
   logic [9:0]  batch_dst[$];
   logic [47:0] batch_wt[$];
   logic [47:0] batch_sum;
   logic        batch_drop;
   int unsigned vcount_reg;
   int unsigned forest_parent[NUM_VERTICES];
   int unsigned forest_rank[NUM_VERTICES];

   kms_pkg::result_type pending_results[$];
   int          error_count = 0;
   int unsigned idle_cycles = 0;
   bit          calm = 1'b0;       // no random idling while set
   bit          send_done = 1'b0;

   task automatic report_mismatch(input string what, input logic [47:0] got,
                                  input logic [47:0] exp);
      $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, exp);
      error_count++;
   endtask

   function automatic int unsigned live_vertices();
      if (vcount_reg < 1) return 1;
      if (vcount_reg > NUM_VERTICES) return NUM_VERTICES;
      return vcount_reg;
   endfunction

   function automatic int unsigned find_root(input int unsigned v);
      int unsigned r, nx;
      r = v;
      while (forest_parent[r] != r) r = forest_parent[r];
      while (forest_parent[v] != r) begin
         nx = forest_parent[v];
         forest_parent[v] = r;
         v = nx;
      end
      return r;
   endfunction

   // Accepts one edge; returns 1 with the spanning-forest result on last.
   function automatic bit predict_forest(input logic [9:0] s, input logic [9:0] d,
                                         input logic [31:0] w, input logic last,
                                         output kms_pkg::result_type res);
      int unsigned nv, chosen, a, b, j;
      logic [47:0] tree, tw;
      logic [9:0]  ts, td;
      nv = live_vertices();
      if (s >= nv || d >= nv || batch_src.size() >= EDGE_CAP) begin
         batch_drop = 1'b1;
      end else begin
         batch_src.push_back(s);
         batch_dst.push_back(d);
         batch_wt.push_back({16'd0, w});
         batch_sum = batch_sum + {16'd0, w};
      end
      if (!last) return 1'b0;
      // stable insertion sort
      for (int i = 1; i < batch_wt.size(); i++) begin
         ts = batch_src[i]; td = batch_dst[i]; tw = batch_wt[i];
         j = i;
         while (j > 0 && batch_wt[j-1] > tw) begin
            batch_src[j] = batch_src[j-1];
            batch_dst[j] = batch_dst[j-1];
            batch_wt[j] = batch_wt[j-1];
            j--;
         end
         batch_src[j] = ts; batch_dst[j] = td; batch_wt[j] = tw;
      end
      for (int v = 0; v < nv; v++) begin
         forest_parent[v] = v;
         forest_rank[v] = 0;
      end
      chosen = 0;
      tree = '0;
      for (int i = 0; i < batch_wt.size() && chosen < nv - 1; i++) begin
         a = find_root(batch_src[i]);
         b = find_root(batch_dst[i]);
         if (a != b) begin
            chosen++;
            tree = tree + batch_wt[i];
            if (forest_rank[a] < forest_rank[b]) forest_parent[a] = b;
            else if (forest_rank[a] > forest_rank[b]) forest_parent[b] = a;
            else begin
               forest_parent[b] = a;
               if (forest_rank[a] < 15) forest_rank[a]++;
            end
         end
      end
      res.saved_weight  = batch_sum - tree;
      res.tree_weight   = tree;
      res.tree_edges    = chosen[9:0];
      res.spanning      = (chosen == nv - 1);
      res.input_dropped = batch_drop;
      batch_src.delete(); batch_dst.delete(); batch_wt.delete();
      batch_sum = '0;
      batch_drop = 1'b0;
      return 1'b1;
   endfunction

   // leaves tvalid high after the accepting edge so items can follow back to back
   task automatic send_edge(input logic [9:0] s, input logic [9:0] d,
                            input logic [31:0] w, input logic last,
                            input bit has_exp, input kms_pkg::result_type exp);
      kms_pkg::result_type res;
      while (!calm && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, w, d, s};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (predict_forest(s, d, w, last, res)) begin
         if (has_exp && res !== exp) begin
            $display("%0t directed row disagrees with predictor", $time);
            error_count++;
         end
         pending_results.push_back(has_exp ? exp : res);
      end
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_vertex_count(input logic [10:0] value);
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      vcount_reg = value;
   endtask

   // random batch, mostly in-range edges over the live vertices
   task automatic random_batch(input int unsigned n);
      int unsigned nv;
      logic [9:0] s, d;
      logic [31:0] w;
      kms_pkg::result_type none;
      none = '0;
      nv = live_vertices();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(19) == 0) begin
            s = 10'($urandom); d = 10'($urandom);
         end else begin
            s = 10'($urandom_range(nv - 1)); d = 10'($urandom_range(nv - 1));
         end
         case ($urandom_range(3))
            0: w = $urandom;
            1: w = $urandom_range(15);
            2: w = 32'hFFFF_FFFF - $urandom_range(3);
            default: w = $urandom_range(1000);
         endcase
         send_edge(s, d, w, i == n - 1, 1'b0, none);
      end
   endtask

   // response side
   always @(posedge clock) begin
      kms_pkg::result_type got, exp;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[47:0], rsp_tdata[95:48], rsp_tdata[105:96],
                   rsp_tdata[106], rsp_tdata[107]};
            if (pending_results.size() == 0) begin
               $display("%0t result with none expected", $time);
               error_count++;
            end else begin
               exp = pending_results.pop_front();
               if (got.saved_weight !== exp.saved_weight)
                  report_mismatch("saved_weight", got.saved_weight, exp.saved_weight);
               if (got.tree_weight !== exp.tree_weight)
                  report_mismatch("tree_weight", got.tree_weight, exp.tree_weight);
               if (got.tree_edges !== exp.tree_edges)
                  report_mismatch("tree_edges", got.tree_edges, exp.tree_edges);
               if (got.spanning !== exp.spanning)
                  report_mismatch("spanning", got.spanning, exp.spanning);
               if (got.input_dropped !== exp.input_dropped)
                  report_mismatch("input_dropped", got.input_dropped, exp.input_dropped);
            end
         end
         rsp_tready <= calm || ($urandom_range(99) >= 7);
      end
   end

   // watchdog on accepted items
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else if (!send_done || pending_results.size() != 0)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   edge_row_type directed [9] = '{
      // vertex_count 1: empty forest, spanning trivially
      '{10'd0, 10'd0, 32'd5, 1'b1, 1'b1, 48'd5, 48'd0, 10'd0, 1'b1, 1'b0},
      // bad id dropped and flagged, last edge dropped too
      '{10'd1, 10'd0, 32'd7, 1'b1, 1'b1, 48'd0, 48'd0, 10'd0, 1'b1, 1'b1},
      // vertex_count 1024 rows below
      '{10'd1023, 10'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0},
      '{10'd0, 10'd1023, 32'd0, 1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0},
      '{10'd5, 10'd5, 32'd1, 1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0},
      '{10'd1, 10'd2, 32'd3, 1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0},
      '{10'd2, 10'd1, 32'd3, 1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0},
      '{10'd1, 10'd1023, 32'hFFFF_FFFF, 1'b1, 1'b0, '0, '0, '0, 1'b0, 1'b0},
      '{10'd512, 10'd341, 32'hAAAA_5555, 1'b1, 1'b0, '0, '0, '0, 1'b0, 1'b0}
   };

   initial begin
      kms_pkg::result_type exp;
      vcount_reg = NUM_VERTICES;
      batch_sum = '0;
      batch_drop = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      calm = 1'b1;
      write_vertex_count(11'd0);   // acts as 1
      foreach (directed[i]) begin
         if (i == 2) write_vertex_count(11'd2047);  // clamps to 1024
         exp = {directed[i].saved, directed[i].tree, directed[i].nedges,
                directed[i].span, directed[i].dropped};
         send_edge(directed[i].src, directed[i].dst, directed[i].wt,
                   directed[i].last, directed[i].known, exp);
      end
      // small random graph over four vertices
      write_vertex_count(11'd4);
      random_batch(8);
      calm = 1'b0;

      // two-vertex graph: parallel edges, self loops and ties
      write_vertex_count(11'd2);
      for (int i = 0; i < 40; i++) begin
         kms_pkg::result_type none;
         none = '0;
         send_edge(10'(i & 1), 10'd1, 32'($urandom_range(3)), i == 39, 1'b0, none);
      end
      // giant weights for a wide sum
      write_vertex_count(11'd3);
      wait_results_drained();
      for (int i = 0; i < 70000; i++) begin
         kms_pkg::result_type none;
         none = '0;
         if (i < 70) send_edge(10'd0, 10'd1, 32'hFFFF_FFFF, 1'b0, 1'b0, none);
         else break;
      end
      random_batch(4);

      for (int n = 0; n < RANDOM_EDGES; ) begin
         int unsigned len;
         case ($urandom_range(5))
            0: write_vertex_count(11'd1024);
            1: write_vertex_count(11'($urandom_range(2, 40)));
            2: write_vertex_count(11'd1);
            default: ;
         endcase
         calm = (n > 400 && n < 600);
         len = $urandom_range(1, 30);
         random_batch(len);
         if ($urandom_range(7) == 0) wait_results_drained();
         n += len;
      end
      calm = 1'b0;
      send_done = 1'b1;
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
